// ===== design/dpcs_pkg.sv =====
// Shared types, constants and the color conversion for the display pixel
// convert and scale block. No dependencies.
`default_nettype none

package dpcs_pkg;

  localparam int SRC_X_W   = 10;
  localparam int SRC_Y_W   = 9;
  localparam int PIXEL_W   = 24;
  localparam int ADDR_W    = 19;
  localparam int COLOR_W   = 32;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 10;

  localparam int DEF_OUT_WIDTH  = 640;
  localparam int DEF_OUT_HEIGHT = 480;

  localparam logic [SRC_X_W-1:0] RESET_WIDTH  = SRC_X_W'(320);
  localparam logic [SRC_Y_W-1:0] RESET_HEIGHT = SRC_Y_W'(240);
  localparam logic [SRC_Y_W-1:0] DOUBLE_HEIGHT = SRC_Y_W'(240);
  localparam logic [COLOR_W-1:0] ALPHA_MASK = 32'hff00_0000;
  localparam logic [4:0] CHAN5_MASK = 5'h1f;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DISPLAY_WIDTH  = 2'd0,
    REG_DISPLAY_HEIGHT = 2'd1,
    REG_PIXEL_FORMAT   = 2'd2
  } reg_index_t;

  typedef enum logic {
    FMT_BGR555 = 1'b0,
    FMT_RGB24  = 1'b1
  } pixel_format_t;

  // one converted pixel on its way to the write sequencer
  typedef struct packed {
    logic [ADDR_W-1:0]  base;
    logic [COLOR_W-1:0] color;
    logic               dbl;
  } burst_t;

  function automatic logic [7:0] widen5(input logic [4:0] v);
    logic [4:0] m;
    m = v & CHAN5_MASK;
    return {m, m[4:2]};
  endfunction

  function automatic logic [COLOR_W-1:0] to_xrgb(input logic [PIXEL_W-1:0] raw,
                                                  input pixel_format_t fmt);
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    if (fmt == FMT_RGB24) begin
      b = raw[7:0];
      g = raw[15:8];
      r = raw[23:16];
    end else begin
      r = widen5(raw[4:0]);
      g = widen5(raw[9:5]);
      b = widen5(raw[14:10]);
    end
    return ALPHA_MASK | {8'h00, r, g, b};
  endfunction

endpackage

`default_nettype wire

// ===== design/dpcs_if.sv =====
// Handshake channels of the display pixel convert and scale block:
// source pixels, output frame writes and register writes. Uses dpcs_pkg.
`default_nettype none

interface dpcs_pixel_if;
  import dpcs_pkg::*;
  logic               valid;
  logic               ready;
  logic [SRC_X_W-1:0] src_x;
  logic [SRC_Y_W-1:0] src_y;
  logic [PIXEL_W-1:0] pixel_value;
  modport source (output valid, src_x, src_y, pixel_value, input ready);
  modport sink   (input valid, src_x, src_y, pixel_value, output ready);
endinterface

interface dpcs_write_if;
  import dpcs_pkg::*;
  logic               valid;
  logic               ready;
  logic [ADDR_W-1:0]  dest_address;
  logic [COLOR_W-1:0] color;
  logic               last;
  modport source (output valid, dest_address, color, last, input ready);
  modport sink   (input valid, dest_address, color, last, output ready);
endinterface

interface dpcs_cfg_if;
  import dpcs_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== design/dpcs_burst.sv =====
// Write sequencer: expands one converted pixel into one or four frame writes
// through a registered output stage. Uses dpcs_pkg and dpcs_write_if.
`default_nettype none

module dpcs_burst
  import dpcs_pkg::*;
#(
  parameter int OUT_WIDTH = DEF_OUT_WIDTH
) (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   in_valid,
  output logic        in_ready,
  input  wire burst_t in_burst,
  dpcs_write_if.source wr
);

  localparam logic [ADDR_W-1:0] ROW_STEP = ADDR_W'(OUT_WIDTH);

  logic              held;
  burst_t            cur;
  logic [1:0]        step;
  logic              load;
  logic              last_now;
  logic              out_valid;
  logic [ADDR_W-1:0] out_addr;
  logic [COLOR_W-1:0] out_color;
  logic              out_last;
  logic [ADDR_W-1:0] addr_next;

  assign load     = held && (!out_valid || wr.ready);
  assign last_now = !cur.dbl || (step == 2'd3);
  assign in_ready = !held || (load && last_now);

  // block order: left, right, then the same pair one row down
  assign addr_next = cur.base + (step[1] ? ROW_STEP : '0) + ADDR_W'(step[0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
      step <= 2'd0;
    end else if (in_valid && in_ready) begin
      held <= 1'b1;
      step <= 2'd0;
    end else if (load) begin
      if (last_now) begin
        held <= 1'b0;
      end
      step <= step + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cur <= in_burst;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (wr.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_addr  <= addr_next;
      out_color <= cur.color;
      out_last  <= last_now;
    end
  end

  assign wr.valid        = out_valid;
  assign wr.dest_address = out_addr;
  assign wr.color        = out_color;
  assign wr.last         = out_last;

endmodule

`default_nettype wire

// ===== design/display_pixel_convert_scale.sv =====
// Top level of the display pixel convert and scale block: registers, window
// geometry, color conversion and address multiply. Uses dpcs_pkg, dpcs_if
// and dpcs_burst.
`default_nettype none

// Places each source pixel into a centered OUT_WIDTH x OUT_HEIGHT frame as
// XRGB32. When the display height is not 240, a pixel is taken every cycle
// while the write channel is ready and gives one write; with height 240 each
// pixel gives a 2x2 block of four writes and the next is taken only as the
// last is issued, as the write channel carries one write per cycle. Pixels
// outside the clipped window are dropped with no write. A pixel passes three
// registers (input, address, output) before its first write. The user must
// write registers through cfg only while no pixel is in flight; not enforced.
module display_pixel_convert_scale
  import dpcs_pkg::*;
#(
  parameter int OUT_WIDTH  = DEF_OUT_WIDTH,
  parameter int OUT_HEIGHT = DEF_OUT_HEIGHT
) (
  input wire logic    clk,
  input wire logic    rst,
  dpcs_cfg_if.sink    cfg,
  dpcs_pixel_if.sink  pix,
  dpcs_write_if.source wr
);

  localparam int XW = (($clog2(OUT_WIDTH + 1) > SRC_X_W + 1) ?
                       $clog2(OUT_WIDTH + 1) : SRC_X_W + 1) + 1;
  localparam int YW = (($clog2(OUT_HEIGHT + 1) > SRC_Y_W + 1) ?
                       $clog2(OUT_HEIGHT + 1) : SRC_Y_W + 1) + 1;
  localparam int PW = XW + YW;
  localparam logic [XW-1:0] OW = XW'(OUT_WIDTH);
  localparam logic [YW-1:0] OH = YW'(OUT_HEIGHT);

  // configuration registers
  logic [SRC_X_W-1:0] display_width;
  logic [SRC_Y_W-1:0] display_height;
  pixel_format_t      pixel_format;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      display_width  <= RESET_WIDTH;
      display_height <= RESET_HEIGHT;
      pixel_format   <= FMT_BGR555;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_DISPLAY_WIDTH:  display_width  <= cfg.data[SRC_X_W-1:0];
        REG_DISPLAY_HEIGHT: display_height <= cfg.data[SRC_Y_W-1:0];
        REG_PIXEL_FORMAT:   pixel_format   <= pixel_format_t'(cfg.data[0]);
        default: ;
      endcase
    end
  end

  // window geometry, settled from the registers
  logic          dbl;
  logic [XW-1:0] dw_raw, dw_clip, dw, srcw, dx;
  logic [YW-1:0] dh_raw, dh_clip, dh, srch, dy;
  logic [XW-1:0] col_in;
  logic [YW-1:0] row_in;
  logic          keep_in;

  always_comb begin
    dbl     = (display_height == DOUBLE_HEIGHT);
    dw_raw  = dbl ? (XW'(display_width) << 1) : XW'(display_width);
    dh_raw  = dbl ? (YW'(display_height) << 1) : YW'(display_height);
    dw_clip = (dw_raw > OW) ? OW : dw_raw;
    dh_clip = (dh_raw > OH) ? OH : dh_raw;
    dw      = dbl ? (dw_clip & ~XW'(1)) : dw_clip;
    dh      = dbl ? (dh_clip & ~YW'(1)) : dh_clip;
    srcw    = dbl ? (dw >> 1) : dw;
    srch    = dbl ? (dh >> 1) : dh;
    dx      = (OW - dw) >> 1;
    dy      = (OH - dh) >> 1;
    keep_in = (srcw != '0) && (srch != '0) &&
              (XW'(pix.src_x) < srcw) && (YW'(pix.src_y) < srch);
    col_in  = dx + (dbl ? (XW'(pix.src_x) << 1) : XW'(pix.src_x));
    row_in  = dy + (dbl ? (YW'(pix.src_y) << 1) : YW'(pix.src_y));
  end

  // input register
  logic               a_valid;
  logic               a_keep;
  logic [XW-1:0]      a_col;
  logic [YW-1:0]      a_row;
  logic [COLOR_W-1:0] a_color;
  logic               a_dbl;
  logic               b_ready;
  logic [PW-1:0]      a_addr_full;
  burst_t             a_burst;

  assign pix.ready = !a_valid || !a_keep || b_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (pix.ready) begin
      a_valid <= pix.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pix.valid && pix.ready) begin
      a_keep  <= keep_in;
      a_col   <= col_in;
      a_row   <= row_in;
      a_color <= to_xrgb(pix.pixel_value, pixel_format);
      a_dbl   <= dbl;
    end
  end

  // row times frame width plus column, kept to the address width
  assign a_addr_full   = (PW'(a_row) * PW'(OUT_WIDTH)) + PW'(a_col);
  assign a_burst.base  = a_addr_full[ADDR_W-1:0];
  assign a_burst.color = a_color;
  assign a_burst.dbl   = a_dbl;

  dpcs_burst #(
    .OUT_WIDTH (OUT_WIDTH)
  ) u_burst (
    .clk      (clk),
    .rst      (rst),
    .in_valid (a_valid && a_keep),
    .in_ready (b_ready),
    .in_burst (a_burst),
    .wr       (wr)
  );

endmodule

`default_nettype wire

// ===== verif/tb_display_pixel_convert_scale.sv =====
`timescale 1ns / 100ps
// Testbench for display_pixel_convert_scale: directed and random source pixels,
// each frame write checked field by field against an in-bench placement model.
// Depends on dpcs_pkg, the dpcs interfaces and the block itself.

module tb_display_pixel_convert_scale;
  import dpcs_pkg::*;

  localparam int FRAME_W = 640;
  localparam int FRAME_H = 480;
  localparam int SETTLE_CYCLES = 8;
  localparam int RANDOM_PHASES = 12;
  localparam int PHASE_PIXELS = 36;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  typedef struct packed {
    logic [ADDR_W-1:0]  dest_address;
    logic [COLOR_W-1:0] color;
    logic               last;
  } frame_write_t;

  logic clk;
  logic rst;

  dpcs_cfg_if   cfg ();
  dpcs_pixel_if pix ();
  dpcs_write_if wr ();

  display_pixel_convert_scale #(
    .OUT_WIDTH (FRAME_W),
    .OUT_HEIGHT(FRAME_H)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cfg(cfg),
    .pix(pix),
    .wr (wr)
  );

  // register shadow
  logic [SRC_X_W-1:0] disp_width;
  logic [SRC_Y_W-1:0] disp_height;
  pixel_format_t      pix_format;

  frame_write_t pending_writes[$];
  int mismatches;
  int writes_seen;
  int pixels_sent;
  int cfg_writes;
  int idle_odds;  // 0: no idling, else one chance in idle_odds per cycle

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("timeout with %0d frame writes outstanding", pending_writes.size());
    $display("status: fail");
    $finish;
  end

  function automatic logic [7:0] stretch5(input logic [4:0] c);
    return {c, c[4:2]};
  endfunction

  function automatic logic [COLOR_W-1:0] xrgb_of(input logic [PIXEL_W-1:0] raw);
    if (pix_format == FMT_RGB24) return {8'hff, raw[23:16], raw[15:8], raw[7:0]};
    return {8'hff, stretch5(raw[4:0]), stretch5(raw[9:5]), stretch5(raw[14:10])};
  endfunction

  function automatic bit doubling();
    return disp_height == DOUBLE_HEIGHT;
  endfunction

  // output window size, clipped to the frame and even when doubling
  function automatic void scaled_size(output int dw, output int dh);
    dw = doubling() ? 2 * int'(disp_width) : int'(disp_width);
    dh = doubling() ? 2 * int'(disp_height) : int'(disp_height);
    if (dw > FRAME_W) dw = FRAME_W;
    if (dh > FRAME_H) dh = FRAME_H;
    if (doubling()) begin
      dw = dw & ~1;
      dh = dh & ~1;
    end
  endfunction

  function automatic void place_pixel(input logic [SRC_X_W-1:0] x,
                                      input logic [SRC_Y_W-1:0] y,
                                      input logic [PIXEL_W-1:0] raw);
    int dw, dh, scale, col, row;
    frame_write_t w;
    scaled_size(dw, dh);
    scale = doubling() ? 2 : 1;
    if (int'(x) >= dw / scale || int'(y) >= dh / scale) return;
    w.color = xrgb_of(raw);
    // doubled block order: top left, top right, bottom left, bottom right
    for (int k = 0; k < scale * scale; k++) begin
      col = (FRAME_W - dw) / 2 + int'(x) * scale + k % scale;
      row = (FRAME_H - dh) / 2 + int'(y) * scale + k / scale;
      w.dest_address = ADDR_W'(row * FRAME_W + col);
      w.last = (k == scale * scale - 1);
      pending_writes.push_back(w);
    end
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t ns: %s", $time, msg);
    mismatches++;
  endtask

  // frame write sink with bursts of back pressure
  initial begin
    int stall_left;
    stall_left = 0;
    wr.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        stall_left--;
        wr.ready <= 1'b0;
      end else if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
        stall_left = $urandom_range(0, 5);
        wr.ready <= 1'b0;
      end else begin
        wr.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    frame_write_t want;
    if (!rst && wr.valid && wr.ready) begin
      writes_seen++;
      if (pending_writes.size() == 0) begin
        report_mismatch($sformatf("unexpected write addr %0d color %h last %b",
                                  wr.dest_address, wr.color, wr.last));
      end else begin
        want = pending_writes.pop_front();
        if (wr.dest_address !== want.dest_address)
          report_mismatch($sformatf("dest_address %0d, wanted %0d",
                                    wr.dest_address, want.dest_address));
        if (wr.color !== want.color)
          report_mismatch($sformatf("color %h, wanted %h at addr %0d",
                                    wr.color, want.color, want.dest_address));
        if (wr.last !== want.last)
          report_mismatch($sformatf("last %b, wanted %b at addr %0d",
                                    wr.last, want.last, want.dest_address));
      end
    end
  end

  // called at a clock edge; leaves valid high so back-to-back pixels stream
  task automatic send_pixel(input logic [SRC_X_W-1:0] x, input logic [SRC_Y_W-1:0] y,
                            input logic [PIXEL_W-1:0] raw);
    if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
      pix.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    pix.valid       <= 1'b1;
    pix.src_x       <= x;
    pix.src_y       <= y;
    pix.pixel_value <= raw;
    do @(posedge clk); while (!pix.ready);
    place_pixel(x, y, raw);
    pixels_sent++;
  endtask

  // stop sending and let every expected write (and any dropped pixel) clear out
  task automatic drain_writes();
    pix.valid <= 1'b0;
    while (pending_writes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DAT_W-1:0] data);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= data;
    do @(posedge clk); while (!cfg.ready);
    case (idx)
      REG_DISPLAY_WIDTH:  disp_width = data;
      REG_DISPLAY_HEIGHT: disp_height = data[SRC_Y_W-1:0];
      REG_PIXEL_FORMAT:   pix_format = pixel_format_t'(data[0]);
      default: ;
    endcase
    cfg_writes++;
  endtask

  task automatic configure(input logic [CFG_DAT_W-1:0] width_data,
                           input logic [CFG_DAT_W-1:0] height_data,
                           input logic [CFG_DAT_W-1:0] format_data);
    write_reg(REG_DISPLAY_WIDTH, width_data);
    write_reg(REG_DISPLAY_HEIGHT, height_data);
    write_reg(REG_PIXEL_FORMAT, format_data);
    cfg.valid <= 1'b0;
  endtask

  task automatic test_reset_geometry();
    // 320x240 doubled fills the whole frame
    send_pixel(0, 0, 24'h000000);
    send_pixel(319, 239, 24'h007fff);
    send_pixel(320, 0, 24'h001234);
    send_pixel(0, 240, 24'h004321);
    send_pixel(5, 7, 24'hab8000 | 24'h0003e0);  // bit 15 and upper byte ignored
    send_pixel(1023, 511, 24'hffffff);
    send_pixel(17, 100, 24'h00001f);
    drain_writes();
  endtask

  task automatic test_rgb24();
    configure(10'd320, 10'd240, CFG_DAT_W'(FMT_RGB24));
    send_pixel(0, 0, 24'hffffff);
    send_pixel(1, 1, 24'h000000);
    send_pixel(100, 50, 24'h123456);
    drain_writes();
  endtask

  task automatic test_single_rate();
    configure(10'd640, 10'd480, CFG_DAT_W'(FMT_BGR555));
    send_pixel(0, 0, 24'h007fff);
    send_pixel(639, 479, 24'hffffff);
    send_pixel(640, 0, 24'h000001);
    drain_writes();
    // widest and tallest settings clip to the frame
    configure(10'd1023, 10'd511, CFG_DAT_W'(FMT_RGB24));
    send_pixel(639, 479, 24'h00ff00);
    send_pixel(0, 479, 24'hff0000);
    send_pixel(1023, 511, 24'h0000ff);
    drain_writes();
  endtask

  task automatic test_odd_doubling();
    configure(10'd321, 10'd240, CFG_DAT_W'(FMT_BGR555));
    send_pixel(319, 239, 24'h005555);
    send_pixel(320, 0, 24'h002aaa);
    drain_writes();
    configure(10'd1, 10'd240, CFG_DAT_W'(FMT_RGB24));
    send_pixel(0, 0, 24'h808080);
    send_pixel(1, 0, 24'h7f7f7f);
    drain_writes();
    // tiny undoubled window of odd size, centered on an odd row offset
    configure(10'd3, 10'd5, CFG_DAT_W'(FMT_BGR555));
    send_pixel(2, 4, 24'h0056b5);
    send_pixel(3, 4, 24'h000000);
    send_pixel(2, 5, 24'h000000);
    drain_writes();
  endtask

  task automatic test_zero_size();
    write_reg(REG_SPARE, 10'h3ff);  // unused index must not disturb anything
    configure(10'd0, 10'd240, CFG_DAT_W'(FMT_BGR555));
    send_pixel(0, 0, 24'h007fff);
    drain_writes();
    configure(10'd5, 10'd0, CFG_DAT_W'(FMT_BGR555));
    send_pixel(0, 0, 24'h007fff);
    drain_writes();
  endtask

  function automatic logic [SRC_X_W-1:0] pick_width();
    case ($urandom_range(0, 9))
      0: return 0;
      1: return 1;
      2: return 320;
      3: return 321;
      4: return 640;
      5: return 1023;
      default: return SRC_X_W'($urandom_range(1, 1023));
    endcase
  endfunction

  function automatic logic [SRC_Y_W-1:0] pick_height();
    case ($urandom_range(0, 11))
      0: return 0;
      1: return 1;
      2, 3, 4: return DOUBLE_HEIGHT;
      5: return 239;
      6: return 241;
      7: return 480;
      8: return 511;
      default: return SRC_Y_W'($urandom_range(1, 511));
    endcase
  endfunction

  task automatic test_random();
    int dw, dh, scale, cols, rows;
    logic [SRC_X_W-1:0] x;
    logic [SRC_Y_W-1:0] y;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      drain_writes();
      case ($urandom_range(0, 2))
        0: idle_odds = 0;
        1: idle_odds = 3;
        default: idle_odds = 8;
      endcase
      if (phase == RANDOM_PHASES - 1) idle_odds = 0;
      // upper data bits of the narrow registers are don't-care
      configure(pick_width(), {1'($urandom), pick_height()},
                {9'($urandom), 1'($urandom)});
      scaled_size(dw, dh);
      scale = doubling() ? 2 : 1;
      cols = dw / scale;
      rows = dh / scale;
      for (int i = 0; i < PHASE_PIXELS; i++) begin
        if (phase == 4 && i == PHASE_PIXELS / 2) drain_writes();
        if (cols != 0 && rows != 0 && $urandom_range(0, 4) != 0) begin
          x = SRC_X_W'($urandom_range(0, cols - 1));
          y = SRC_Y_W'($urandom_range(0, rows - 1));
        end else begin
          x = SRC_X_W'($urandom);
          y = SRC_Y_W'($urandom);
        end
        send_pixel(x, y, PIXEL_W'($urandom));
      end
    end
    drain_writes();
  endtask

  initial begin
    rst             <= 1'b1;
    pix.valid       <= 1'b0;
    pix.src_x       <= '0;
    pix.src_y       <= '0;
    pix.pixel_value <= '0;
    cfg.valid       <= 1'b0;
    cfg.index       <= REG_DISPLAY_WIDTH;
    cfg.data        <= '0;
    disp_width  = RESET_WIDTH;
    disp_height = RESET_HEIGHT;
    pix_format  = FMT_BGR555;
    mismatches  = 0;
    writes_seen = 0;
    pixels_sent = 0;
    cfg_writes  = 0;
    idle_odds   = 3;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_geometry();
    test_rgb24();
    test_single_rate();
    test_odd_doubling();
    test_zero_size();
    test_random();

    $display("sent %0d source pixels in both formats, doubled and single rate,",
             pixels_sent);
    $display("checked %0d frame writes over %0d register writes", writes_seen, cfg_writes);
    if (mismatches == 0 && pending_writes.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/dpcs_pkg.sv
design/dpcs_if.sv
design/dpcs_burst.sv
design/display_pixel_convert_scale.sv
verif/tb_display_pixel_convert_scale.sv
